>>> rtl/core/dmg_pkg.sv
// Package for the directional grey convolution: widths, constants, register
// indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dmg_pkg;
    localparam int PIX_W   = 10;
    localparam int COEF_W  = 10;
    localparam int SUM_W   = 28;
    localparam int T_W     = 30;
    localparam int MAG_W   = 29;
    localparam int RECIP_SHIFT = 30;
    localparam logic [MAG_W-1:0] RECIP = 29'd357913942;
    localparam logic [11:0] ROW_MAX = 12'hFFF;

    localparam logic [1:0] CFG_KERNEL_SIZE = 2'd0;
    localparam logic [1:0] CFG_MASK_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_WIDTH  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_WAIT,
        ST_TERM_A,
        ST_TERM_B,
        ST_OUT
    } dmg_state_t;

    typedef struct packed {
        logic shift_en;
        logic load;
        logic scan_en;
    } dmg_cell_ctrl_t;
endpackage
`default_nettype wire

>>> rtl/core/dmg_cell.sv
// One window cell: holds a channel sum in the window row chain and a copy
// in the serial scan chain. Uses dmg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmg_cell (
    input  wire logic                        aclk,
    input  wire dmg_pkg::dmg_cell_ctrl_t     ctrl,
    input  wire logic [dmg_pkg::PIX_W-1:0]   win_in,
    input  wire logic [dmg_pkg::PIX_W-1:0]   scan_in,
    output logic      [dmg_pkg::PIX_W-1:0]   win_q,
    output logic      [dmg_pkg::PIX_W-1:0]   scan_q
);
    import dmg_pkg::*;

    logic [PIX_W-1:0] win_reg;
    logic [PIX_W-1:0] scan_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            win_reg <= win_in;
        end
        if (ctrl.load) begin
            scan_reg <= win_reg;
        end else if (ctrl.scan_en) begin
            scan_reg <= scan_in;
        end
    end

    assign win_q  = win_reg;
    assign scan_q = scan_reg;
endmodule
`default_nettype wire

>>> rtl/core/dmg_term.sv
// Accumulator for one mask term: 3*sum + coef*sample is registered, then an
// exact truncating divide by three through a reciprocal product. Uses dmg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmg_term (
    input  wire logic                              aclk,
    input  wire logic                              clr,
    input  wire logic                              a_en,
    input  wire logic                              b_en,
    input  wire logic signed [dmg_pkg::COEF_W-1:0] coef,
    input  wire logic        [dmg_pkg::PIX_W-1:0]  sample,
    output logic signed      [dmg_pkg::SUM_W-1:0]  sum
);
    import dmg_pkg::*;

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [T_W-1:0]     sum_ext;
    logic signed [T_W-1:0]     prod;
    logic signed [T_W-1:0]     t_val;
    logic                      neg_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [MAG_W-1:0]          mag_next;
    logic [2*MAG_W-1:0]        full;
    logic [SUM_W-1:0]          quot;

    always_comb begin
        sum_ext  = T_W'(sum_reg);
        prod     = T_W'(coef) * T_W'($signed({1'b0, sample}));
        t_val    = (sum_ext <<< 1) + sum_ext + prod;
        mag_next = t_val[T_W-1] ? MAG_W'(-t_val) : MAG_W'(t_val);
        full     = (2*MAG_W)'(mag_reg) * (2*MAG_W)'(RECIP);
        quot     = full[RECIP_SHIFT +: SUM_W];
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            neg_reg <= t_val[T_W-1];
            mag_reg <= mag_next;
        end
        if (clr) begin
            sum_reg <= '0;
        end else if (b_en) begin
            sum_reg <= neg_reg ? -$signed(quot) : $signed(quot);
        end
    end

    assign sum = sum_reg;
endmodule
`default_nettype wire

>>> rtl/core/directional_mask_grey_convolution.sv
// Top level of the directional grey convolution: line store, window chain of
// dmg_cell, term accumulator dmg_term and the sequencer. Uses dmg_pkg.
//
//  Port group | Direction | Transfer content
//  s_*        | in        | one BGR pixel, frame start flag in tuser
//  m_*        | out       | filtered value with centre column and row
//  cfg_*      | in        | register write, no read-back
//
// Each pixel passes IDLE, READ and SHIFT; a pixel with a result then waits in
// WAIT and is scanned serially through one shared term unit before OUT.
// A result waiting on m_tready stalls only the start of the next scan.
// Reset is synchronous; the line store and window hold no reset value.
`timescale 1ns / 1ps
`default_nettype none
module directional_mask_grey_convolution #(
    parameter int MAX_SIZE  = 7,
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // blue, green, red
    input  wire logic        s_tuser,  // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // filtered_value, centre_column, centre_row
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_wdata
);
    import dmg_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int KW = 4;
    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NCELL = MAX_SIZE * MAX_SIZE;
    localparam int LS_ROWS = (MAX_SIZE > 1) ? MAX_SIZE - 1 : 1;
    localparam int KMAX = (MAX_SIZE % 2 == 1) ? MAX_SIZE : MAX_SIZE - 1;

    logic [2:0]             kernel_size_reg;
    logic signed [7:0]      mask_weight_reg;
    logic [10:0]            line_width_reg;
    logic [CW-1:0]          column_count_reg;
    logic [11:0]            row_count_reg;
    logic [CW-1:0]          c_reg;
    logic [11:0]            row_reg;
    logic [PIX_W-1:0]       s_reg;
    logic [LS_ROWS*PIX_W-1:0] rd_reg;
    dmg_state_t             state_reg, state_next;
    logic [IW-1:0]          scan_row_reg, scan_col_reg;
    logic                   m_tvalid_reg;
    logic [7:0]             fv_reg;
    logic [9:0]             cc_reg;
    logic [11:0]            cr_reg;

    logic [LW-1:0]          lw_ext, w_eff, c_plus;
    logic [KW-1:0]          k_raw, k_eff, h, base, ri, cj;
    logic                   fs, accept, hit, active, last_cell;
    logic [CW-1:0]          col0, c_acc, col_n;
    logic [11:0]            row0, row1, row_n;
    logic [PIX_W-1:0]       pix_sum;
    logic [PIX_W-1:0]       col_vec [MAX_SIZE];
    logic [PIX_W-1:0]       win_q [NCELL];
    logic [PIX_W-1:0]       scan_q [NCELL];
    logic [PIX_W-1:0]       scan_s;
    dmg_cell_ctrl_t         cell_ctrl;
    logic                   term_clr, term_a, term_b, out_load;
    logic signed [COEF_W-1:0] wt, coef;
    logic signed [SUM_W-1:0]  acc_sum;

    always_comb begin
        lw_ext = LW'(line_width_reg);
        if (lw_ext == '0) begin
            w_eff = LW'(1);
        end else if (lw_ext > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        k_raw = {1'b0, kernel_size_reg | 3'd1};
        k_eff = (k_raw > KW'(MAX_SIZE)) ? KW'(KMAX) : k_raw;
        h     = k_eff >> 1;
        base  = KW'(MAX_SIZE) - k_eff;

        fs      = s_tuser;
        pix_sum = PIX_W'(s_tdata[7:0]) + PIX_W'(s_tdata[15:8]) + PIX_W'(s_tdata[23:16]);
        col0    = fs ? '0 : column_count_reg;
        row0    = fs ? '0 : row_count_reg;
        if (LW'(col0) >= w_eff) begin
            c_acc = '0;
            row1  = (row0 == ROW_MAX) ? row0 : row0 + 12'd1;
        end else begin
            c_acc = col0;
            row1  = row0;
        end
        c_plus = LW'(c_acc) + LW'(1);
        if (c_plus >= w_eff) begin
            col_n = '0;
            row_n = (row1 == ROW_MAX) ? row1 : row1 + 12'd1;
        end else begin
            col_n = CW'(c_plus);
            row_n = row1;
        end

        hit = (LW'(c_reg) >= LW'(k_eff - 4'd1)) && (row_reg >= 12'(k_eff - 4'd1));

        wt        = COEF_W'(mask_weight_reg);
        active    = (KW'(scan_row_reg) >= base) && (KW'(scan_col_reg) >= base);
        ri        = KW'(scan_row_reg) - base;
        cj        = KW'(scan_col_reg) - base;
        scan_s    = active ? scan_q[0] : '0;
        if (!active) begin
            coef = '0;
        end else if (ri < h) begin
            coef = -wt;
        end else if (ri == h && cj == h) begin
            coef = -(wt <<< 1);
        end else begin
            coef = wt;
        end
        last_cell = (scan_row_reg == IW'(MAX_SIZE - 1)) && (scan_col_reg == IW'(MAX_SIZE - 1));
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cell_ctrl  = '0;
        term_clr   = 1'b0;
        term_a     = 1'b0;
        term_b     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cell_ctrl.shift_en = 1'b1;
                state_next = hit ? ST_WAIT : ST_IDLE;
            end
            ST_WAIT: begin
                if (!m_tvalid_reg) begin
                    cell_ctrl.load = 1'b1;
                    term_clr   = 1'b1;
                    state_next = ST_TERM_A;
                end
            end
            ST_TERM_A: begin
                term_a     = 1'b1;
                state_next = ST_TERM_B;
            end
            ST_TERM_B: begin
                term_b            = 1'b1;
                cell_ctrl.scan_en = 1'b1;
                if (last_cell) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_TERM_A;
                end
            end
            ST_OUT: begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            kernel_size_reg  <= 3'd3;
            mask_weight_reg  <= 8'sd1;
            line_width_reg   <= 11'd1024;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
            scan_row_reg     <= '0;
            scan_col_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_KERNEL_SIZE: kernel_size_reg <= cfg_wdata[2:0];
                    CFG_MASK_WEIGHT: mask_weight_reg <= $signed(cfg_wdata[7:0]);
                    CFG_LINE_WIDTH:  line_width_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                column_count_reg <= col_n;
                row_count_reg    <= row_n;
            end
            if (term_clr) begin
                scan_row_reg <= '0;
                scan_col_reg <= '0;
            end else if (term_b) begin
                if (scan_col_reg == IW'(MAX_SIZE - 1)) begin
                    scan_col_reg <= '0;
                    scan_row_reg <= scan_row_reg + IW'(1);
                end else begin
                    scan_col_reg <= scan_col_reg + IW'(1);
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            c_reg   <= c_acc;
            row_reg <= row1;
            s_reg   <= pix_sum;
        end
        if (out_load) begin
            if (acc_sum < 0) begin
                fv_reg <= 8'd0;
            end else if (acc_sum > SUM_W'(255)) begin
                fv_reg <= 8'd255;
            end else begin
                fv_reg <= acc_sum[7:0];
            end
            cc_reg <= 10'(LW'(c_reg) - LW'(h));
            cr_reg <= row_reg - 12'(h);
        end
    end

    generate
        if (MAX_SIZE > 1) begin : g_lines
            logic [LS_ROWS*PIX_W-1:0] line_mem [MAX_WIDTH];
            logic [LS_ROWS*PIX_W-1:0] wr_word;
            always_comb begin
                wr_word = rd_reg >> PIX_W;
                wr_word[(LS_ROWS-1)*PIX_W +: PIX_W] = s_reg;
            end
            always_ff @(posedge aclk) begin
                if (accept) begin
                    rd_reg <= line_mem[c_acc];
                end
                if (state_reg == ST_SHIFT) begin
                    line_mem[c_reg] <= wr_word;
                end
            end
            for (genvar r = 0; r < MAX_SIZE - 1; r++) begin : g_cv
                assign col_vec[r] = rd_reg[r*PIX_W +: PIX_W];
            end
        end else begin : g_nolines
            assign rd_reg = '0;
        end
    endgenerate
    assign col_vec[MAX_SIZE-1] = s_reg;

    generate
        for (genvar n = 0; n < NCELL; n++) begin : g_cell
            logic [PIX_W-1:0] w_in, sc_in;
            if (n % MAX_SIZE == MAX_SIZE - 1) begin : g_edge
                assign w_in = col_vec[n / MAX_SIZE];
            end else begin : g_mid
                assign w_in = win_q[n+1];
            end
            if (n == NCELL - 1) begin : g_tail
                assign sc_in = '0;
            end else begin : g_link
                assign sc_in = scan_q[n+1];
            end
            dmg_cell u_cell (
                .aclk    (aclk),
                .ctrl    (cell_ctrl),
                .win_in  (w_in),
                .scan_in (sc_in),
                .win_q   (win_q[n]),
                .scan_q  (scan_q[n])
            );
        end
    endgenerate

    dmg_term u_term (
        .aclk   (aclk),
        .clr    (term_clr),
        .a_en   (term_a),
        .b_en   (term_b),
        .coef   (coef),
        .sample (scan_s),
        .sum    (acc_sum)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, cr_reg, cc_reg, fv_reg};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");
    a_result_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the end of a scan");
    a_scan_needs_free_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctrl.load |-> !m_tvalid)
        else $error("scan started while a result is pending");
`endif
endmodule
`default_nettype wire
